// File: rtl/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
package sfr_pkg;

  // Sizes
  localparam int unsigned ByteW       = 8;
  localparam int unsigned MaxPatBytes = 8;
  localparam int unsigned MaxRepBytes = 8;
  localparam int unsigned LenW        = 4;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned WinW        = MaxPatBytes * ByteW;
  localparam int unsigned RepW        = MaxRepBytes * ByteW;
  localparam int unsigned JobW        = (WinW > RepW) ? WinW : RepW;
  localparam int unsigned FifoDepth   = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatLen   = 2'd0,
    RegPatBytes = 2'd1,
    RegRepLen   = 2'd2,
    RegRepBytes = 2'd3
  } reg_idx_e;

  // One emit job: up to eight bytes, oldest in the low byte
  typedef struct packed {
    logic [JobW-1:0] bytes;
    logic [LenW-1:0] num;    // results in this job, 1..8
    logic            eot;    // job closes the text
    logic            blank;  // empty end marker, no data byte
  } job_t;

endpackage

// File: rtl/sfr_front.sv
// Front end: config registers, pending window, match check and job build.
module sfr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sfr_pkg::ByteW-1:0]     text_byte_i,
  input  logic                          end_of_text_i,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output sfr_pkg::job_t                 job_o
);

  localparam int unsigned LenW = sfr_pkg::LenW;
  localparam int unsigned NPat = sfr_pkg::MaxPatBytes;
  localparam int unsigned BW   = sfr_pkg::ByteW;

  // Configuration registers
  logic [LenW-1:0]              pat_len_q;
  logic [sfr_pkg::CfgDataW-1:0] pat_q;
  logic [LenW-1:0]              rep_len_q;
  logic [sfr_pkg::CfgDataW-1:0] rep_q;

  // Pending window
  logic [NPat-1:0][BW-1:0] win_q, win_d, w, win_sh;
  logic [LenW-1:0]         cnt_q, cnt_d;

  logic [LenW-1:0] len_eff, rep_eff, cnt_use, cnt_p1;
  logic            fire, full, match;
  sfr_pkg::job_t   job;

  assign in_ready_o = !fifo_full_i;
  assign fire       = in_valid_i && in_ready_o;

  // Clamp lengths into range
  always_comb begin
    if (pat_len_q == '0) begin
      len_eff = LenW'(1);
    end else if (pat_len_q > LenW'(NPat)) begin
      len_eff = LenW'(NPat);
    end else begin
      len_eff = pat_len_q;
    end
    if (rep_len_q > LenW'(sfr_pkg::MaxRepBytes)) begin
      rep_eff = LenW'(sfr_pkg::MaxRepBytes);
    end else begin
      rep_eff = rep_len_q;
    end
  end

  // Append the new byte and compare against the pattern
  always_comb begin
    cnt_use = (cnt_q >= len_eff) ? '0 : cnt_q;
    cnt_p1  = cnt_use + LenW'(1);
    full    = (cnt_p1 == len_eff);
    w       = win_q;
    w[cnt_use[$clog2(NPat > 1 ? NPat : 2)-1:0]] = text_byte_i;
    match   = 1'b1;
    for (int k = 0; k < NPat; k++) begin
      if ((LenW'(k) < len_eff) && (w[k] != pat_q[k*BW +: BW])) begin
        match = 1'b0;
      end
    end
    for (int k = 0; k < NPat - 1; k++) begin
      win_sh[k] = w[k+1];
    end
    win_sh[NPat-1] = w[NPat-1];
  end

  // Decide what this item emits and what stays pending
  always_comb begin
    job.eot   = end_of_text_i;
    job.blank = 1'b0;
    win_d     = w;
    if (full && match) begin
      job.bytes = sfr_pkg::JobW'(rep_q[sfr_pkg::RepW-1:0]);
      job.num   = rep_eff;
      cnt_d     = '0;
    end else if (full) begin
      job.bytes = sfr_pkg::JobW'(w);
      job.num   = end_of_text_i ? len_eff : LenW'(1);
      cnt_d     = end_of_text_i ? '0 : len_eff - LenW'(1);
      win_d     = win_sh;
    end else begin
      job.bytes = sfr_pkg::JobW'(w);
      job.num   = end_of_text_i ? cnt_p1 : '0;
      cnt_d     = end_of_text_i ? '0 : cnt_p1;
    end
    // Text ends with nothing to show: send the empty marker
    if (end_of_text_i && (job.num == '0)) begin
      job.bytes = '0;
      job.num   = LenW'(1);
      job.blank = 1'b1;
    end
  end

  assign push_o = fire && (job.num != '0);
  assign job_o  = job;

  // Control and config state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= LenW'(1);
      pat_q     <= '0;
      rep_len_q <= '0;
      rep_q     <= '0;
      cnt_q     <= '0;
    end else begin
      // a pattern length write empties the window
      if (cfg_we_i && (cfg_idx_i == sfr_pkg::RegPatLen)) begin
        cnt_q <= '0;
      end else if (fire) begin
        cnt_q <= cnt_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfr_pkg::RegPatLen:   pat_len_q <= cfg_wdata_i[LenW-1:0];
          sfr_pkg::RegPatBytes: pat_q     <= cfg_wdata_i;
          sfr_pkg::RegRepLen:   rep_len_q <= cfg_wdata_i[LenW-1:0];
          sfr_pkg::RegRepBytes: rep_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Window bytes, no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      win_q <= win_d;
    end
  end

endmodule

// File: rtl/sfr_fifo.sv
// Short job queue between front and back end.
module sfr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output sfr_pkg::job_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned Depth = sfr_pkg::FifoDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sfr_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/sfr_back.sv
// Back end: plays out one job a result at a time on the output channel.
module sfr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fifo_empty_i,
  input  sfr_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfr_pkg::ByteW-1:0] out_byte_o,
  output logic                      byte_valid_o,
  output logic                      last_of_run_o,
  output logic                      text_done_o
);

  localparam int unsigned LenW = sfr_pkg::LenW;

  logic                     act_q;
  logic [sfr_pkg::JobW-1:0] bytes_q;
  logic [LenW-1:0]          left_q;
  logic                     eot_q, blank_q;
  logic                     last, load;

  assign last = (left_q == LenW'(1));
  assign load = !fifo_empty_i && (!act_q || (out_ready_i && last));
  assign pop_o = load;

  // Result fields from the held job
  assign out_valid_o   = act_q;
  assign out_byte_o    = blank_q ? '0 : bytes_q[sfr_pkg::ByteW-1:0];
  assign byte_valid_o  = !blank_q;
  assign last_of_run_o = last;
  assign text_done_o   = last && eot_q;

  // Busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (load) begin
      act_q <= 1'b1;
    end else if (out_ready_i && last) begin
      act_q <= 1'b0;
    end
  end

  // Job payload: load a new job or step to the next byte
  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= job_i.bytes;
      left_q  <= job_i.num;
      eot_q   <= job_i.eot;
      blank_q <= job_i.blank;
    end else if (act_q && out_ready_i && !last) begin
      bytes_q <= bytes_q >> sfr_pkg::ByteW;
      left_q  <= left_q - LenW'(1);
    end
  end

endmodule

// File: rtl/stream_find_replace.sv
// An item's first result reaches the output after passing the job queue and
// the back end's job register. Throughput: one item per cycle while out_ready_i
// is high and each item yields at most one result; an item that yields several
// results holds the output until all are taken, and in_ready_o drops once the
// two-entry job queue fills behind it.
// Reset (rst_ni low, async): window empty, queue empty, output idle,
// pattern length 1, replacement length 0, pattern and replacement bytes 0.
module stream_find_replace (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sfr_pkg::ByteW-1:0]     text_byte_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sfr_pkg::ByteW-1:0]     out_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_of_run_o,
  output logic                          text_done_o
);

  logic          push, pop, full, empty;
  sfr_pkg::job_t push_job, pop_job;

  // Classify items into jobs
  sfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .fifo_full_i   (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Job queue
  sfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // Emit results
  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

endmodule

// File: rtl/sfr_checker.sv
// Port-level checks for the find-and-replace block, bound to the top level.
module sfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sfr_pkg::ByteW-1:0]     out_byte_o,
  input logic                          byte_valid_o,
  input logic                          last_of_run_o,
  input logic                          text_done_o
);

  // Text end always closes the item's run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_done_o |-> last_of_run_o)
    else $error("text_done without last_of_run");

  // Empty marker only at text end, with a zero byte
  a_blank_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> text_done_o && (out_byte_o == '0))
    else $error("bad empty end marker");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o) && $stable(text_done_o))
    else $error("stalled result changed");

  // Nothing is emitted in the cycle right after reset release
  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result out of reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the streaming find-and-replace block.
module tb_top;
  import sfr_pkg::*;

  // One output item as the checker sees it
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has_data;
    logic             run_end;
    logic             text_end;
  } out_item_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [ByteW-1:0]    text_byte_i   = '0;
  logic                end_of_text_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [ByteW-1:0]    out_byte_o;
  logic                byte_valid_o;
  logic                last_of_run_o;
  logic                text_done_o;

  // Rewriter state mirrored on the testbench side
  logic [ByteW-1:0] win_q [MaxPatBytes];
  int unsigned      win_cnt   = 0;
  logic [LenW-1:0]  pat_len_r = 4'd1;
  logic [WinW-1:0]  pat_r     = '0;
  logic [LenW-1:0]  rep_len_r = 4'd0;
  logic [RepW-1:0]  rep_r     = '0;

  out_item_t   rewritten_q [$];
  int unsigned mismatches      = 0;
  int unsigned snd_idle_pct    = 15;
  int unsigned rcv_idle_pct    = 80;
  int unsigned rcv_hold_cycles = 0;

  stream_find_replace u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Pattern length as the block uses it: zero acts as one, clamp at max
  function automatic int unsigned eff_pat_len();
    if (pat_len_r == 0) return 1;
    if (pat_len_r > MaxPatBytes) return MaxPatBytes;
    return pat_len_r;
  endfunction

  // Run one text byte through the window and queue the bytes it releases
  function automatic void rewrite_byte(input logic [ByteW-1:0] b, input logic eot);
    out_item_t   run [$];
    int unsigned plen;
    int unsigned rlen;
    bit          hit;
    plen = eff_pat_len();
    rlen = (rep_len_r > MaxRepBytes) ? MaxRepBytes : rep_len_r;
    if (win_cnt >= plen) win_cnt = 0;
    win_q[win_cnt] = b;
    win_cnt++;
    if (win_cnt == plen) begin
      hit = 1'b1;
      for (int k = 0; k < plen; k++)
        if (win_q[k] != pat_r[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (int k = 0; k < rlen; k++)
          run.push_back(out_item_t'{rep_r[8*k +: 8], 1'b1, 1'b0, 1'b0});
        win_cnt = 0;
      end else begin
        run.push_back(out_item_t'{win_q[0], 1'b1, 1'b0, 1'b0});
        for (int k = 1; k < win_cnt; k++) win_q[k-1] = win_q[k];
        win_cnt--;
      end
    end
    // end of text flushes the window, or leaves an empty marker
    if (eot) begin
      for (int k = 0; k < win_cnt; k++)
        run.push_back(out_item_t'{win_q[k], 1'b1, 1'b0, 1'b0});
      win_cnt = 0;
      if (run.size() == 0) run.push_back(out_item_t'{ByteW'(0), 1'b0, 1'b0, 1'b0});
    end
    if (run.size() > 0) begin
      run[run.size()-1].run_end  = 1'b1;
      run[run.size()-1].text_end = eot;
    end
    foreach (run[i]) rewritten_q.push_back(run[i]);
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] v);
    case (idx)
      RegPatLen: begin
        pat_len_r = v[LenW-1:0];
        win_cnt   = 0;  // pending bytes are dropped
      end
      RegPatBytes: pat_r     = v[WinW-1:0];
      RegRepLen:   rep_len_r = v[LenW-1:0];
      RegRepBytes: rep_r     = v[RepW-1:0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one item, with random idle cycles ahead of it
  task automatic send_item(input logic [ByteW-1:0] b, input logic eot);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    rewrite_byte(b, eot);
  endtask

  // Stop sending, wait for every queued byte, then let the pipe go quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_config();
    logic [LenW-1:0] plen;
    logic [LenW-1:0] rlen;
    case ($urandom_range(7))
      0:       plen = 4'd0;
      1:       plen = LenW'($urandom_range(15, 9));
      default: plen = LenW'($urandom_range(8, 1));
    endcase
    case ($urandom_range(7))
      0:       rlen = LenW'($urandom_range(15, 9));
      default: rlen = LenW'($urandom_range(8, 0));
    endcase
    // sometimes leave the pattern alone so the window survives
    if ($urandom_range(2) != 0) begin
      write_reg(RegPatBytes, {$urandom, $urandom});
      write_reg(RegPatLen, CfgDataW'(plen));
    end
    write_reg(RegRepLen, CfgDataW'(rlen));
    write_reg(RegRepBytes, {$urandom, $urandom});
  endtask

  // Text built from pattern copies, broken prefixes and noise
  task automatic send_text(input int unsigned n_units, input bit close,
                           output int unsigned n_sent);
    logic [ByteW-1:0] text [$];
    int unsigned      plen;
    int unsigned      cut;
    plen = eff_pat_len();
    repeat (n_units) begin
      case ($urandom_range(9))
        0, 1, 2, 3: for (int k = 0; k < plen; k++) text.push_back(pat_r[8*k +: 8]);
        4, 5: begin
          cut = $urandom_range(plen);
          for (int k = 0; k < cut; k++) text.push_back(pat_r[8*k +: 8]);
          text.push_back(ByteW'($urandom_range(255)));
        end
        6:       text.push_back(pat_r[8*$urandom_range(plen-1) +: 8]);
        default: text.push_back(ByteW'($urandom_range(255)));
      endcase
    end
    foreach (text[i]) send_item(text[i], close && (i == text.size() - 1));
    n_sent = text.size();
  endtask

  // Out of reset: one-byte pattern 0x00, empty replacement
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);  // deleted last byte leaves an empty marker
  endtask

  task automatic test_directed_patterns();
    drain_results();
    write_reg(RegPatLen, CfgDataW'(2));
    write_reg(RegPatBytes, 64'h6261);
    write_reg(RegRepLen, CfgDataW'(3));
    write_reg(RegRepBytes, 64'h5A5958);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b1);

    // zero pattern length acts as one, oversize replacement clamps to eight
    drain_results();
    write_reg(RegPatLen, CfgDataW'(0));
    write_reg(RegPatBytes, 64'hFF);
    write_reg(RegRepLen, CfgDataW'(15));
    write_reg(RegRepBytes, 64'h0123_4567_89AB_CDEF);
    send_item(8'hFF, 1'b1);
    send_item(8'h01, 1'b0);

    // oversize pattern length clamps to eight; a full match is deleted
    drain_results();
    write_reg(RegPatLen, CfgDataW'(15));
    write_reg(RegPatBytes, 64'hFF00_A55A_3CC3_0180);
    write_reg(RegRepLen, CfgDataW'(0));
    for (int k = 0; k < 8; k++) send_item(pat_r[8*k +: 8], k == 7);

    // pattern length rewritten with bytes pending drops them
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);
    drain_results();
    write_reg(RegPatLen, CfgDataW'(8));
    send_item(8'h44, 1'b1);
  endtask

  task automatic test_random_texts(input int unsigned budget);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
        load_config();
      end
      send_text($urandom_range(6, 1), $urandom_range(4) != 0, n);
      sent += n;
    end
  endtask

  // Long output stall with eight bytes per item, then a full pause
  task automatic test_output_stall();
    drain_results();
    write_reg(RegPatLen, CfgDataW'(1));
    write_reg(RegPatBytes, 64'h41);
    write_reg(RegRepLen, CfgDataW'(8));
    write_reg(RegRepBytes, {$urandom, $urandom});
    rcv_hold_cycles = 400;
    repeat (11) send_item(8'h41, 1'b0);
    send_item(8'h41, 1'b1);
    drain_results();
    repeat (6) send_item(8'h41, 1'b0);
    send_item(8'h42, 1'b1);
  endtask

  // Output ready: random stalls, or a counted hold-off when requested
  initial forever begin
    @(posedge clk_i);
    if (rcv_hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      rcv_hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted output item with the oldest queued one
  initial forever begin
    out_item_t want;
    @(posedge clk_i);
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (rewritten_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item expected none got %0h/%0b/%0b/%0b", $time,
                 out_byte_o, byte_valid_o, last_of_run_o, text_done_o);
      end else begin
        want = rewritten_q.pop_front();
        check_field("out_byte", want.data, out_byte_o);
        check_field("byte_valid", ByteW'(want.has_data), ByteW'(byte_valid_o));
        check_field("last_of_run", ByteW'(want.run_end), ByteW'(last_of_run_o));
        check_field("text_done", ByteW'(want.text_end), ByteW'(text_done_o));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_patterns();
    test_random_texts(85);
    snd_idle_pct = 80;
    rcv_idle_pct = 15;
    test_random_texts(85);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_texts(85);
    test_output_stall();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_fifo.sv
rtl/sfr_back.sv
rtl/stream_find_replace.sv
rtl/sfr_checker.sv
tb/tb_top.sv
